// ----- hw/rtl/mcl_pkg.sv -----
// Shared types, constants and tables for the month calendar layout block.
// Used by mcl_emit and month_calendar_layout_core; no dependencies.
package mcl_pkg;

  // Input beat: one month of one year
  typedef struct packed {
    logic [3:0]  month;
    logic [13:0] year;
  } mcl_in_t;

  // Result beat: one calendar cell
  typedef struct packed {
    logic [4:0] day_number;
    logic [2:0] week_row;
    logic [2:0] weekday_column;
    logic       last_of_month;
    logic       bad_date;
  } mcl_out_t;

  // Command from the sequencer to the cell emitter
  typedef struct packed {
    logic       go;     // start walking the days of a month
    logic       err;    // send the single bad-date beat
    logic [4:0] shown;  // number of cells in the month
    logic [2:0] col;    // weekday of the first cell
  } mcl_emit_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIVB,
    S_CNT,
    S_MOD,
    S_COL,
    S_COLMOD,
    S_EMIT
  } mcl_state_t;

  // Reciprocal multipliers for the shared unit (valid for operands below 2^14)
  localparam logic [14:0] K_DIV100  = 15'd10486;  // x/100 = (x*K) >> 20
  localparam int          SH_DIV100 = 20;
  localparam logic [14:0] K_DIV7    = 15'd18725;  // x/7   = (x*K) >> 17
  localparam int          SH_DIV7   = 17;

  localparam logic [13:0] YEAR_CENT_BASE  = 14'd1701;
  localparam logic [13:0] YEAR_QUAD_BASE  = 14'd1601;
  localparam logic [13:0] YEAR_GREG_RULE  = 14'd1800;
  localparam logic [13:0] YEAR_CHANGE     = 14'd1752;
  localparam logic [13:0] YEAR_MAX        = 14'd9999;
  localparam logic [4:0]  SHORT_SEPT_DAYS = 5'd19;
  localparam logic [4:0]  COMMON_FEB_DAYS = 5'd28;
  localparam logic [4:0]  SKIPPED_DAYS    = 5'd11;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;
  localparam logic [3:0]  MONTH_SEP       = 4'd9;

  // Month lengths with a 29-day February
  function automatic logic [4:0] base_month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd2:                                       d = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // Days before the first of month m, with a 29-day February
  function automatic logic [8:0] base_days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd60;
      4'd4:    d = 9'd91;
      4'd5:    d = 9'd121;
      4'd6:    d = 9'd152;
      4'd7:    d = 9'd182;
      4'd8:    d = 9'd213;
      4'd9:    d = 9'd244;
      4'd10:   d = 9'd274;
      4'd11:   d = 9'd305;
      4'd12:   d = 9'd335;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/month_calendar_layout_core.sv -----
// Top level of the month calendar layout block: sequencer around mcl_mul and mcl_emit.
// Depends on mcl_pkg, mcl_mul and mcl_emit.
//
// A month/year beat is taken when start is high and busy is low. A valid date
// then keeps busy high during the weekday arithmetic, all of it through
// one shared reciprocal multiplier (three products per January 1 for two years,
// the last one issued again in S_MOD, then one for the first weekday of the
// month), followed by one result beat per shown day (19 to 31). Results appear
// on out_data for exactly one cycle each, flagged by out_valid; the receiver
// cannot stall them and must take every beat. A bad month or year yields a
// single error beat in the next cycle and busy never rises.
module month_calendar_layout_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mcl_pkg::mcl_in_t  in_data,
  output logic              out_valid,
  output mcl_pkg::mcl_out_t out_data
);
  import mcl_pkg::*;

  mcl_state_t    state_r, state_nxt;
  logic [3:0]    month_r, month_nxt;
  logic [13:0]   yr_r, yr_nxt;
  logic          pass_r, pass_nxt;
  logic [7:0]    qa_r, qa_nxt;
  logic [13:0]   opnd_r, opnd_nxt;
  logic [2:0]    first_r, first_nxt;
  logic [4:0]    shown_r, shown_nxt;
  logic [13:0]   mul_x;
  logic [14:0]   mul_k;
  logic [28:0]   mul_p;
  logic [7:0]    q100;
  logic [10:0]   q7;
  logic [13:0]   times7;
  logic [13:0]   rem_full;
  logic [2:0]    rem7;
  logic [14:0]   cnt;
  logic          greg_late;
  logic [2:0]    wk_diff;
  logic          feb_short;
  logic          sept_short;
  logic [8:0]    days_before;
  logic [8:0]    col_sum;
  logic          bad;
  logic          emit_active;
  mcl_emit_cmd_t cmd;

  mcl_mul u_mul (
    .clk (clk),
    .x   (mul_x),
    .k   (mul_k),
    .p_r (mul_p)
  );

  mcl_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .active_r    (emit_active),
    .out_valid_r (out_valid),
    .out_data_r  (out_data)
  );

  assign busy = (state_r != S_IDLE);

  // Quotients and remainder taken from the shared product
  always_comb begin
    q100     = mul_p[SH_DIV100+7:SH_DIV100];
    q7       = mul_p[SH_DIV7+10:SH_DIV7];
    times7   = {q7, 3'b000} - {3'b000, q7};
    rem_full = opnd_r - times7;
    rem7     = rem_full[2:0];
  end

  // Weekday count of January 1 before reduction modulo 7
  always_comb begin
    greg_late = yr_r > YEAR_GREG_RULE;
    cnt = 15'd4 + {1'b0, yr_r} + ({1'b0, yr_r} + 15'd3) / 15'd4;
    if (greg_late) begin
      cnt = cnt - {7'd0, qa_r} + {9'd0, q100[7:2]};
    end
    if (yr_r > YEAR_CHANGE) begin
      cnt = cnt + 15'd3;
    end
  end

  // Year kind from the weekday step to the next January 1
  always_comb begin
    wk_diff    = (rem7 >= first_r) ? (rem7 - first_r) : (rem7 + 3'd7 - first_r);
    feb_short  = 1'b0;
    sept_short = 1'b0;
    case (wk_diff)
      3'd1:    feb_short  = 1'b1;
      3'd2:    ;
      default: sept_short = 1'b1;
    endcase
    days_before = base_days_before(month_r);
    if (feb_short && month_r > MONTH_FEB) begin
      days_before = days_before - 9'd1;
    end
    if (sept_short && month_r > MONTH_SEP) begin
      days_before = days_before - 9'(SKIPPED_DAYS);
    end
    col_sum = days_before + {6'd0, first_r};
  end

  assign bad = (in_data.month < 4'd1) || (in_data.month > 4'd12) ||
               (in_data.year < 14'd1) || (in_data.year > YEAR_MAX);

  // Sequence the shared multiplier and hand the month to the emitter
  always_comb begin
    state_nxt = state_r;
    month_nxt = month_r;
    yr_nxt    = yr_r;
    pass_nxt  = pass_r;
    qa_nxt    = qa_r;
    opnd_nxt  = opnd_r;
    first_nxt = first_r;
    shown_nxt = shown_r;
    mul_x     = 14'd0;
    mul_k     = K_DIV100;
    cmd       = '{go: 1'b0, err: 1'b0, shown: shown_r, col: rem7};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (bad) begin
            cmd.err = 1'b1;
          end else begin
            month_nxt = in_data.month;
            yr_nxt    = in_data.year;
            pass_nxt  = 1'b0;
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        mul_x     = yr_r - YEAR_CENT_BASE;
        mul_k     = K_DIV100;
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        qa_nxt    = q100;
        mul_x     = yr_r - YEAR_QUAD_BASE;
        mul_k     = K_DIV100;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        opnd_nxt  = cnt[13:0];
        mul_x     = cnt[13:0];
        mul_k     = K_DIV7;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // Hold the modulo-7 product so the weekday survives into S_COL
        mul_x = opnd_r;
        mul_k = K_DIV7;
        if (!pass_r) begin
          first_nxt = rem7;
          yr_nxt    = yr_r + 14'd1;
          pass_nxt  = 1'b1;
          state_nxt = S_SETUP;
        end else begin
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        // rem7 still holds the weekday of the next January 1 here
        shown_nxt = base_month_days(month_r);
        if (feb_short && month_r == MONTH_FEB) begin
          shown_nxt = COMMON_FEB_DAYS;
        end
        if (sept_short && month_r == MONTH_SEP) begin
          shown_nxt = SHORT_SEPT_DAYS;
        end
        opnd_nxt  = {5'd0, col_sum};
        mul_x     = {5'd0, col_sum};
        mul_k     = K_DIV7;
        state_nxt = S_COLMOD;
      end
      S_COLMOD: begin
        cmd.go    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!emit_active) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    month_r <= month_nxt;
    yr_r    <= yr_nxt;
    pass_r  <= pass_nxt;
    qa_r    <= qa_nxt;
    opnd_r  <= opnd_nxt;
    first_r <= first_nxt;
    shown_r <= shown_nxt;
  end

endmodule

// ----- hw/rtl/mcl_mul.sv -----
// Shared multiplier of the layout sequencer: operand times reciprocal constant.
// Depends on nothing but its ports; product is registered.
module mcl_mul (
  input  logic        clk,
  input  logic [13:0] x,
  input  logic [14:0] k,
  output logic [28:0] p_r
);

  logic [28:0] p_nxt;

  // Multiply the issued operand by the selected reciprocal
  always_comb begin
    p_nxt = {15'd0, x} * {14'd0, k};
  end

  // Hold the product for the next sequencer step
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ----- hw/rtl/mcl_emit.sv -----
// Cell emitter: walks the days of one month and drives the result beats.
// Depends on mcl_pkg for the result and command types.
module mcl_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcl_pkg::mcl_emit_cmd_t cmd,
  output logic                   active_r,
  output logic                   out_valid_r,
  output mcl_pkg::mcl_out_t      out_data_r
);
  import mcl_pkg::*;

  logic       active_nxt;
  logic       out_valid_nxt;
  mcl_out_t   out_data_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] shown_r, shown_nxt;
  logic [2:0] col_r, col_nxt;
  logic [2:0] row_r, row_nxt;
  logic [4:0] day;
  logic       last;

  // Day number of the current cell, with the September 1752 gap
  always_comb begin
    day = idx_r + 5'd1;
    if (shown_r == SHORT_SEPT_DAYS && day >= 5'd3) begin
      day = day + SKIPPED_DAYS;
    end
    last = (idx_r + 5'd1) == shown_r;
  end

  // Load a new month, emit one cell per cycle, or send the error beat
  always_comb begin
    active_nxt    = active_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    shown_nxt     = shown_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (cmd.err) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{day_number: 5'd0, week_row: 3'd0, weekday_column: 3'd0,
                        last_of_month: 1'b1, bad_date: 1'b1};
    end else if (cmd.go) begin
      active_nxt = 1'b1;
      idx_nxt    = 5'd0;
      shown_nxt  = cmd.shown;
      col_nxt    = cmd.col;
      row_nxt    = 3'd0;
    end else if (active_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{day_number: day, week_row: row_r, weekday_column: col_r,
                        last_of_month: last, bad_date: 1'b0};
      idx_nxt       = idx_r + 5'd1;
      if (col_r == 3'd6) begin
        col_nxt = 3'd0;
        row_nxt = row_r + 3'd1;
      end else begin
        col_nxt = col_r + 3'd1;
      end
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    shown_r    <= shown_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
  end

endmodule
